/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; compiled out with
// NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/acpd_pkg.sv */
// ---------------------------------------------------------------------------
// acpd_pkg
// Shared types and constants of the alternating coil pulse driver.
// ---------------------------------------------------------------------------
package acpd_pkg;

  localparam int unsigned SAFETY_TICKS = 50;

  localparam logic [15:0] PULSE_MS_RST  = 16'd200;
  localparam logic [15:0] PAUSE_MS_RST  = 16'd100;
  localparam logic [31:0] MIN_GAP_RST   = 32'd0;

  // register indexes
  typedef enum logic [1:0] {
    REG_PULSE_MS   = 2'd0,
    REG_PAUSE_MS   = 2'd1,
    REG_MIN_GAP_MS = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_TICK    = 2'd0,
    K_TRIGGER = 2'd1,
    K_FORCE_A = 2'd2,
    K_FORCE_B = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_STARTED = 2'd1,
    ST_GAP     = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DRIVE = 2'd1,
    PH_COAST = 2'd2,
    PH_SPARE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [31:0] min_gap_ms;
    logic [15:0] pause_ms;
    logic [15:0] pulse_ms;
  } cfg_t;

  typedef struct packed {
    logic    busy_res;
    status_t status;
    logic    drive_in2;
    logic    drive_in1;
  } result_t;

endpackage

/* src/acpd_core.sv */
// ---------------------------------------------------------------------------
// acpd_core
// Pulse sequencer state: gap guard, alternation, drive/coast timing.
// ---------------------------------------------------------------------------
module acpd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  acpd_pkg::kind_t  kind,
  input  logic             burst,
  input  acpd_pkg::cfg_t   cfg,
  output acpd_pkg::result_t res,
  output logic             busy
);
  import acpd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] timer, timer_next;
  logic        pulse_is_b, pulse_is_b_next;
  logic        last_was_a, last_was_a_next;
  logic [31:0] since, since_next;
  logic        stamp, stamp_next;

  logic [17:0] need_sum;
  logic [31:0] need;
  logic [15:0] tdec;
  logic        start_req, coast_req, fin_req;
  status_t     status;

  assign busy = (phase != PH_IDLE);

  always_comb begin
    phase_next      = phase;
    timer_next      = timer;
    pulse_is_b_next = pulse_is_b;
    last_was_a_next = last_was_a;
    since_next      = since;
    stamp_next      = stamp;
    status          = ST_NONE;
    start_req       = 1'b0;
    coast_req       = 1'b0;
    fin_req         = 1'b0;
    tdec            = (timer != 16'd0) ? timer - 16'd1 : 16'd0;
    need_sum        = {2'b00, cfg.pulse_ms} + {2'b00, cfg.pause_ms}
                    + 18'(SAFETY_TICKS);
    need            = (cfg.min_gap_ms > {14'd0, need_sum}) ? cfg.min_gap_ms
                                                           : {14'd0, need_sum};

    unique case (kind)
      K_TICK: begin
        if (since != '1) since_next = since + 32'd1;
        if (phase != PH_IDLE) begin
          timer_next = tdec;
          if (tdec == 16'd0) begin
            if (phase == PH_DRIVE) coast_req = 1'b1;
            else fin_req = 1'b1;
          end
        end
      end
      K_TRIGGER: begin
        if (phase != PH_IDLE) begin
          status = ST_BUSY;
        end else if (!burst && since < need) begin
          status = ST_GAP;
        end else begin
          status          = ST_STARTED;
          start_req       = 1'b1;
          pulse_is_b_next = last_was_a;
          last_was_a_next = ~last_was_a;
          stamp_next      = 1'b1;
        end
      end
      K_FORCE_A, K_FORCE_B: begin
        if (phase != PH_IDLE) begin
          status = ST_BUSY;
        end else begin
          status          = ST_STARTED;
          start_req       = 1'b1;
          pulse_is_b_next = (kind == K_FORCE_B);
          stamp_next      = 1'b0;
        end
      end
      default: status = ST_NONE;
    endcase

    if (start_req) begin
      if (cfg.pulse_ms == 16'd0) begin
        coast_req = 1'b1;
      end else begin
        phase_next = PH_DRIVE;
        timer_next = cfg.pulse_ms;
      end
    end

    if (coast_req) begin
      if (cfg.pause_ms == 16'd0) begin
        fin_req = 1'b1;
      end else begin
        phase_next = PH_COAST;
        timer_next = cfg.pause_ms;
      end
    end

    // gap stamp is taken when a triggered pulse completes
    if (fin_req) begin
      phase_next = PH_IDLE;
      timer_next = 16'd0;
      if (stamp_next) begin
        since_next = 32'd0;
        stamp_next = 1'b0;
      end
    end
  end

  always_comb begin
    res.drive_in1 = (phase_next == PH_DRIVE) && !pulse_is_b_next;
    res.drive_in2 = (phase_next == PH_DRIVE) && pulse_is_b_next;
    res.status    = status;
    res.busy_res  = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      timer      <= 16'd0;
      pulse_is_b <= 1'b0;
      last_was_a <= 1'b0;
      since      <= 32'd0;
      stamp      <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      timer      <= timer_next;
      pulse_is_b <= pulse_is_b_next;
      last_was_a <= last_was_a_next;
      since      <= since_next;
      stamp      <= stamp_next;
    end
  end

endmodule

/* src/alternating_coil_pulse_driver.sv */
// ---------------------------------------------------------------------------
// alternating_coil_pulse_driver
// H-bridge pulse driver for a stepping clock coil; triggered pulses alternate polarity.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser kind, tdata allow_burst
//  m_*      | out       | m_tvalid/m_tready  | tdata drive/status/busy
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_addr index, cfg_data value
//
//  One item per cycle: the sequencer state and the output register both load
//  at the accept edge, so the result is offered from the next cycle on.
//  The output register is the only stall point; s_tready drops only while
//  a result is held and m_tready is low.
//  Synchronous reset restores register defaults and an idle sequencer.
//  cfg_ready is always high; each transfer to a mapped index writes one register.
// ---------------------------------------------------------------------------
module alternating_coil_pulse_driver (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] allow_burst, [7:1] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] drive_in1, [1] drive_in2, [3:2] status,
                                 // [4] busy_res, [7:5] zero
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import acpd_pkg::*;

`include "assert_macros.svh"

  cfg_t    cfg;
  result_t res;
  logic    take;
  logic    busy;
  logic    busy_req;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ms   <= PULSE_MS_RST;
      cfg.pause_ms   <= PAUSE_MS_RST;
      cfg.min_gap_ms <= MIN_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_PULSE_MS:   cfg.pulse_ms   <= cfg_data[15:0];
        REG_PAUSE_MS:   cfg.pause_ms   <= cfg_data[15:0];
        REG_MIN_GAP_MS: cfg.min_gap_ms <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // accept whenever the output slot is free or being emptied
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  acpd_core u_core (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .kind  (kind_t'(s_tuser)),
    .burst (s_tdata[0]),
    .cfg   (cfg),
    .res   (res),
    .busy  (busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {3'b000, res};
    end
  end

  // start request accepted while a pulse is running
  assign busy_req = take && busy && (s_tuser != K_TICK);

  // both bridge inputs high would short the supply
  `ASSERT_SAME(a_no_shoot, clk, rst, m_tvalid, !(m_tdata[0] && m_tdata[1]))
  // drive level implies the pulse is still in progress
  `ASSERT_SAME(a_drive_busy, clk, rst, m_tvalid && (m_tdata[0] || m_tdata[1]), m_tdata[4])
  // a request arriving while busy is refused and leaves the sequencer busy
  `ASSERT_NEXT(a_refuse_busy, clk, rst, busy_req, m_tdata[3:2] == ST_BUSY && m_tdata[4] && busy)

endmodule
